[rtl/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants for the rolling mean filter: field widths,
// register map, queue status and the controller state encodings.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W       = 32;
  localparam int SUM_W          = 38;
  localparam int WIN_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;

  // Register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd10;

  // Queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Saturation limits of the quotient magnitude and the output
  localparam logic [SUM_W-1:0] MAG_POS_LIM = SUM_W'({1'b0, {31{1'b1}}});
  localparam logic [SUM_W-1:0] MAG_NEG_LIM = SUM_W'({1'b1, {31{1'b0}}});
  localparam logic [SAMPLE_W-1:0] MEAN_MAX = {1'b0, {31{1'b1}}};
  localparam logic [SAMPLE_W-1:0] MEAN_MIN = {1'b1, {31{1'b0}}};

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'b01,
    FR_CALC = 2'b10
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_DIV  = 4'b0010,
    BK_SAT  = 4'b0100,
    BK_HOLD = 4'b1000
  } back_state_t;

endpackage

[rtl/rmf_front.sv]
// ----------------------------------------------------------------------------
// rmf_front
// Accepts samples, keeps the delay line, the running sum and the sample
// count, and pushes the updated sum with its divisor into the queue.
// ----------------------------------------------------------------------------
module rmf_front #(
  parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF,
  parameter int CW         = $clog2(MAX_WINDOW + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rmf_pkg::WIN_W-1:0]   window_length,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] sample,
  input  logic                        starts_column,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        push,
  output logic [rmf_pkg::SUM_W-1:0]   push_sum,
  output logic [CW-1:0]               push_count,
  input  rmf_pkg::q_status_t          q_status
);
  import rmf_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int DW = CW + 1;
  localparam int EXT_W = SUM_W - SAMPLE_W;

  front_state_t state;

  // Delay line memory: one write and one registered read per beat
  logic [SAMPLE_W-1:0] history [MAX_WINDOW];

  logic [AW-1:0]       wp;
  logic [AW-1:0]       wp_next;
  logic [AW-1:0]       old_addr;
  logic [CW-1:0]       seen;
  logic [CW-1:0]       seen_eff;
  logic [CW-1:0]       win_eff;
  logic [DW-1:0]       old_diff;
  logic                win_full;
  logic                accept;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;

  // Per-beat payload held for the update cycle
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    base;
  logic                drop;
  logic [CW-1:0]       cnt;

  assign in_ready = (state == FR_IDLE);
  assign accept   = in_valid && in_ready;

  // Clamp the window register to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      win_eff = CW'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(window_length);
    end
  end

  // Start flag restarts the count; the window is full once count reaches it
  assign seen_eff = starts_column ? '0 : seen;
  assign win_full = (seen_eff >= win_eff);

  // Address of the sample leaving the window, modulo the line depth
  assign old_diff = DW'(wp) - DW'(win_eff);
  assign old_addr = old_diff[DW-1] ? AW'(old_diff + DW'(MAX_WINDOW)) : AW'(old_diff);
  assign wp_next  = (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;

  // Add the new sample, drop the leaving one; wraps within the sum width
  assign sum_next = base + {{EXT_W{smp[SAMPLE_W-1]}}, smp}
                  - (drop ? {{EXT_W{old_smp[SAMPLE_W-1]}}, old_smp} : '0);

  assign push       = (state == FR_CALC) && !q_status.full;
  assign push_sum   = sum_next;
  assign push_count = cnt;

  // Write the new sample, read the leaving one (read before write)
  always_ff @(posedge clk) begin
    if (accept) begin
      history[wp] <= sample;
      old_smp     <= history[old_addr];
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      smp  <= sample;
      base <= starts_column ? '0 : sum;
      drop <= win_full;
      cnt  <= win_full ? win_eff : seen_eff + 1'b1;
    end
  end

  // Control: pointer, count, sum and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      wp    <= '0;
      seen  <= '0;
      sum   <= '0;
    end else begin
      case (state)
        FR_IDLE: begin
          if (accept) begin
            wp    <= wp_next;
            seen  <= (seen_eff < CW'(MAX_WINDOW)) ? seen_eff + 1'b1 : seen_eff;
            state <= FR_CALC;
          end
        end
        FR_CALC: begin
          if (!q_status.full) begin
            sum   <= sum_next;
            state <= FR_IDLE;
          end
        end
        default: begin
          state <= FR_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/rmf_queue.sv]
// ----------------------------------------------------------------------------
// rmf_queue
// Short FIFO carrying sum and divisor pairs from the front to the divider.
// ----------------------------------------------------------------------------
module rmf_queue #(
  parameter int DW = 45
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [DW-1:0]      push_data,
  input  logic               pop,
  output logic [DW-1:0]      pop_data,
  output rmf_pkg::q_status_t q_status
);
  import rmf_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  logic [DW-1:0] entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;

  assign q_status.full  = (count == (QW + 1)'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_data       = entries[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QW + 1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

[rtl/rmf_divider.sv]
// ----------------------------------------------------------------------------
// rmf_divider
// Back end: takes a sum and divisor from the queue, divides one quotient bit
// per cycle toward zero, saturates to 32 bits and holds the mean for output.
// ----------------------------------------------------------------------------
module rmf_divider #(
  parameter int CW = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rmf_pkg::q_status_t          q_status,
  output logic                        pop,
  input  logic [rmf_pkg::SUM_W-1:0]   pop_sum,
  input  logic [CW-1:0]               pop_count,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] mean,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import rmf_pkg::*;

  back_state_t          state;
  logic [SUM_W-1:0]     dvd;
  logic [CW-1:0]        divisor;
  logic [CW-1:0]        rem;
  logic [CW:0]          rem_sh;
  logic                 ge;
  logic                 neg;
  logic [DIV_CNT_W-1:0] steps;

  assign pop       = (state == BK_IDLE) && !q_status.empty;
  assign out_valid = (state == BK_HOLD);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor});

  // Datapath: load magnitude, iterate, saturate
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          neg     <= pop_sum[SUM_W-1];
          dvd     <= pop_sum[SUM_W-1] ? (~pop_sum + 1'b1) : pop_sum;
          divisor <= pop_count;
          rem     <= '0;
        end
      end
      BK_DIV: begin
        rem <= ge ? CW'(rem_sh - {1'b0, divisor}) : CW'(rem_sh);
        dvd <= {dvd[SUM_W-2:0], ge};
      end
      BK_SAT: begin
        if (neg) begin
          mean <= (dvd > MAG_NEG_LIM) ? MEAN_MIN : (~dvd[SAMPLE_W-1:0] + 1'b1);
        end else begin
          mean <= (dvd > MAG_POS_LIM) ? MEAN_MAX : dvd[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      steps <= '0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop) begin
            steps <= DIV_CNT_W'(SUM_W);
            state <= BK_DIV;
          end
        end
        BK_DIV: begin
          steps <= steps - 1'b1;
          if (steps == DIV_CNT_W'(1)) begin
            state <= BK_SAT;
          end
        end
        BK_SAT: begin
          state <= BK_HOLD;
        end
        BK_HOLD: begin
          if (out_ready) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  a_valid_after_sat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == BK_SAT))
    else $error("mean shown without a finished division");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    pop |-> (pop_count != '0))
    else $error("zero divisor taken from queue");
`endif

endmodule

[rtl/rolling_mean_filter.sv]
// Path from sample beat to mean valid: front update, queue pop, the
//   divider steps, saturate; it takes longer while the divider is busy.
// The sustained sample rate is set by the bit-serial divider (load,
//   divider steps, saturate, output beat); the queue and the front
//   take three more samples while a mean waits.
// Reset: clears sum, count, pointer and queue; window 10; delay line kept.
// ----------------------------------------------------------------------------
// rolling_mean_filter
// Simple moving average of signed Q16.16 samples with an APB window register.
// ----------------------------------------------------------------------------
module rolling_mean_filter #(
  parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // Sample input
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] sample,
  input  logic                             starts_column,
  input  logic                             in_valid,
  output logic                             in_ready,
  // Mean output
  output logic signed [rmf_pkg::SAMPLE_W-1:0] mean,
  output logic                             out_valid,
  input  logic                             out_ready
);
  import rmf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int QDW = SUM_W + CW;

  logic [WIN_W-1:0] window_length;
  logic             reg_sel;
  logic             push;
  logic             pop;
  logic [SUM_W-1:0] push_sum;
  logic [CW-1:0]    push_count;
  logic [QDW-1:0]   pop_data;
  q_status_t        q_status;

  // Register access
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_WINDOW);
  assign prdata  = reg_sel ? APB_DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_length <= pwdata[WIN_W-1:0];
    end
  end

  rmf_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .CW         (CW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .sample        (sample),
    .starts_column (starts_column),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .push          (push),
    .push_sum      (push_sum),
    .push_count    (push_count),
    .q_status      (q_status)
  );

  rmf_queue #(
    .DW (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_count}),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  rmf_divider #(
    .CW (CW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (pop),
    .pop_sum   (pop_data[QDW-1:CW]),
    .pop_count (pop_data[CW-1:0]),
    .mean      (mean),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rolling mean filter. A short table of
// hand-picked samples and window settings comes first, then random columns
// with random window writes between them, including two runs that push the
// running sum past its range. Every mean beat is compared against the
// table's mean where a row gives one, else an in-bench moving-average model.
// ----------------------------------------------------------------------------
module tb;
  import rmf_pkg::*;

  localparam int TOTAL_ITEMS   = 1425;
  localparam int HIST_DEPTH    = 64;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 50;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_SPACING  = 450;
  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = APB_ADDR_W'(4 * REG_WINDOW);
  localparam logic [SAMPLE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic signed [63:0] MEAN_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MEAN_LO = -64'sh0000_0000_8000_0000;

  typedef enum logic [0:0] {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [SAMPLE_W-1:0]   value;
    logic                  col_start;
    logic                  known;
    logic [SAMPLE_W-1:0]   mean;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset window of ten: extremes and truncation toward zero
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    // run past the window so old samples drop out
    '{ROW_SAMPLE, 32'h0001_8000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h7FFF_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'hFFFE_8000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    // zero window acts as one; first sample continues the column
    '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h4000_0000, 1'b1, 1'b1, 32'h4000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFB, 1'b0, 1'b1, 32'hFFFF_FFFB},
    // oversized window saturates to the delay line depth
    '{ROW_WINDOW, 32'd127,       1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0064, 1'b1, 1'b1, 32'h0000_0064},
    '{ROW_SAMPLE, 32'hFFFF_FF37, 1'b0, 1'b1, 32'hFFFF_FFCE},
    '{ROW_WINDOW, 32'd1,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{ROW_WINDOW, 32'd64,        1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0003, 1'b1, 1'b1, 32'h0000_0003},
    '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b1, 32'h0000_0003},
    '{ROW_SAMPLE, 32'hFFFF_FFF0, 1'b0, 1'b0, 32'h0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  starts_column = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   mean;
  logic                  out_valid;
  logic                  out_ready = 1'b0;

  // Moving average model state
  logic [SAMPLE_W-1:0]   shadow_history [HIST_DEPTH];
  logic [SUM_W-1:0]      shadow_sum;
  int unsigned           shadow_seen;
  int unsigned           shadow_wp;
  logic [WIN_W-1:0]      shadow_window;

  logic [SAMPLE_W-1:0]   pending_means [$];
  int                    mismatches;
  int                    samples_fed;
  int                    means_checked;

  rolling_mean_filter dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sample        (sample),
    .starts_column (starts_column),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mean          (mean),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the model by one sample and return the mean it should produce
  function automatic logic [SAMPLE_W-1:0] predict_mean(input logic [SAMPLE_W-1:0] s,
                                                       input logic col_start);
    int unsigned       w;
    int unsigned       n;
    int unsigned       old;
    logic [SAMPLE_W-1:0] gone;
    logic signed [63:0] total;
    logic signed [63:0] divisor;
    logic signed [63:0] q;
    w = (shadow_window == 0) ? 1 : int'(shadow_window);
    if (w > HIST_DEPTH) w = HIST_DEPTH;
    if (col_start) begin
      shadow_sum = '0;
      shadow_seen = 0;
    end
    shadow_sum = shadow_sum + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    if (shadow_seen >= w) begin
      old = (shadow_wp + HIST_DEPTH - w) % HIST_DEPTH;
      gone = shadow_history[old];
      shadow_sum = shadow_sum - {{(SUM_W-SAMPLE_W){gone[SAMPLE_W-1]}}, gone};
      n = w;
    end else begin
      n = shadow_seen + 1;
    end
    shadow_history[shadow_wp] = s;
    shadow_wp = (shadow_wp + 1) % HIST_DEPTH;
    if (shadow_seen < HIST_DEPTH) shadow_seen++;
    total = {{(64-SUM_W){shadow_sum[SUM_W-1]}}, shadow_sum};
    divisor = n;
    q = total / divisor;
    if (q > MEAN_HI) q = MEAN_HI;
    if (q < MEAN_LO) q = MEAN_LO;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(input bit heavy);
    int unsigned pick;
    pick = $urandom_range(9);
    if (heavy) pick = pick % 4;
    case (pick)
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'($urandom_range(512)) - 32'd256;
      3: return {16'($urandom_range(15)) - 16'd8, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4: return WIN_W'($urandom_range(127, 65));
      5, 6: return WIN_W'($urandom_range(16, 1));
      default: return WIN_W'($urandom_range(63, 2));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected mean %h, got %h", $realtime, what, want, got);
  endtask

  // Offer one sample beat, hold it until taken, then queue its mean
  task automatic feed_sample(input logic [SAMPLE_W-1:0] s, input logic col_start,
                             input logic known, input logic [SAMPLE_W-1:0] typed_mean);
    logic [SAMPLE_W-1:0] m;
    while (!(samples_fed >= 500 && samples_fed < 750) && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= s;
    starts_column <= col_start;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    m = predict_mean(s, col_start);
    pending_means.push_back(known ? typed_mean : m);
    samples_fed++;
  endtask

  // Drop valid and wait until every queued mean has come back
  task automatic drain_means();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    drain_means();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= APB_DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_window = w;
  endtask

  // Fill a full window, shrink it to one and swap polarity, then widen it
  // again so each new sample subtracts the opposite extreme and the sum wraps
  task automatic run_sum_drift(input logic [SAMPLE_W-1:0] hi, input logic [SAMPLE_W-1:0] lo);
    write_window(7'd64);
    for (int k = 0; k < 64; k++) feed_sample(hi, k == 0, 1'b0, '0);
    write_window(7'd1);
    for (int k = 0; k < 64; k++) feed_sample(lo, 1'b0, 1'b0, '0);
    write_window(7'd64);
    for (int k = 0; k < 64; k++) feed_sample(hi, 1'b0, 1'b0, '0);
  endtask

  // Mean sink: check each beat, stall at random, and hold off for long
  // stretches while the source is still offering samples
  initial begin
    int hold_left;
    int next_hold_at;
    logic [SAMPLE_W-1:0] want;
    hold_left = 0;
    next_hold_at = 200;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        means_checked++;
        if (pending_means.size() == 0) begin
          flag_mismatch("unexpected beat", '0, mean);
        end else begin
          want = pending_means.pop_front();
          if (mean !== want) flag_mismatch("mean", want, mean);
        end
      end
      if (hold_left == 0 && means_checked >= next_hold_at && in_valid) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (means_checked >= 500 && means_checked < 750) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  // Stimulus
  initial begin
    int phase;
    int len;
    int roll;
    int guard;
    bit heavy;
    shadow_sum = '0;
    shadow_seen = 0;
    shadow_wp = 0;
    shadow_window = WINDOW_RESET;
    mismatches = 0;
    samples_fed = 0;
    means_checked = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WINDOW)
        write_window(DIRECTED[i].value[WIN_W-1:0]);
      else
        feed_sample(DIRECTED[i].value, DIRECTED[i].col_start,
                    DIRECTED[i].known, DIRECTED[i].mean);
    end

    // Random columns, window writes between phases
    phase = 0;
    while (samples_fed < TOTAL_ITEMS) begin
      phase++;
      if (phase == 4) run_sum_drift(Q_MAX, Q_MIN);
      if (phase == 9) run_sum_drift(Q_MIN, Q_MAX);
      roll = $urandom_range(99);
      if (roll < 60) write_window(pick_window());
      else if (roll < 75) drain_means();
      len = $urandom_range(80, 1);
      heavy = ($urandom_range(4) == 0);
      for (int k = 0; k < len; k++)
        feed_sample(random_sample(heavy),
                    (k == 0) ? 1'($urandom_range(1)) : 1'($urandom_range(99) < 3),
                    1'b0, '0);
    end

    // Wind down
    in_valid <= 1'b0;
    guard = 0;
    while (pending_means.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_means.size() != 0) begin
      mismatches++;
      $display("%0d expected means never arrived", pending_means.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
